// ----- sv/pfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Palette fit analyzer package
// Shared types, codes and constants for the palette fit analyzer.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_CHECK_ENABLE = 2'd2;

  localparam logic [2:0] CLASS_1BPP    = 3'd0;
  localparam logic [2:0] CLASS_2BPP    = 3'd1;
  localparam logic [2:0] CLASS_4BPP    = 3'd2;
  localparam logic [2:0] CLASS_8BPP    = 3'd3;
  localparam logic [2:0] CLASS_NO_PAL  = 3'd4;

  localparam int LIMIT_1BPP = 2;
  localparam int LIMIT_2BPP = 4;
  localparam int LIMIT_4BPP = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic       is_transparent;
    logic       is_grayscale;
    logic [2:0] colour_class;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rd_pend;
    logic last;
    logic out_free;
  } sts_t;

endpackage : pfa_pkg
`default_nettype wire

// ----- sv/palette_fit_analyzer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Palette fit analyzer unit
// Gathers distinct colors, transparency and grayscale over an RGBA8 pixel
// stream and reports the palette class on the last pixel of each image.
// ----------------------------------------------------------------------------
// Each pixel is compared against the distinct colors gathered so far by a
// sequential search through a single-port color memory, one entry per
// cycle. The input stays stalled while the stored colors (at most
// TABLE_DEPTH) are searched and the table is updated; the search is
// skipped when the table is empty or has overflowed. The last pixel of
// an image also waits until a previous result held by out_stall is
// taken and the new one is loaded. Results are registered, so a new
// image can start while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module palette_fit_analyzer_unit #(
  parameter int TABLE_DEPTH = pfa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pfa_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pfa_pkg::out_item_t                  out_item
);
  import pfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfa_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && !in_stall))
    else $error("Pixel loaded without an accepted item.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("Result loaded over an item that was not taken.");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("Result appeared without an emit command.");

  a_scan_commit_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_rd && cmd.commit))
    else $error("Table read and commit issued together.");

endmodule : palette_fit_analyzer_unit
`default_nettype wire

// ----- sv/pfa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Palette fit analyzer controller
// Sequences pixel intake, the color table search, the table update and
// the hand-off of the per-image result.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pfa_pkg::sts_t sts,
  output pfa_pkg::cmd_t      cmd
);
  import pfa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done && !sts.rd_pend) begin
          state_nxt = sts.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_rd = !sts.scan_done;
        cmd.commit  = sts.scan_done && !sts.rd_pend;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : pfa_ctrl
`default_nettype wire

// ----- sv/pfa_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Palette fit analyzer datapath
// Holds the configuration, the image flags, the distinct color memory with
// its search counter, and the output register.
// ----------------------------------------------------------------------------
module pfa_dp #(
  parameter int TABLE_DEPTH = pfa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire pfa_pkg::in_item_t                  in_item,
  input  wire pfa_pkg::cmd_t                      cmd,
  output pfa_pkg::sts_t                           sts,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output pfa_pkg::out_item_t                      out_item
);
  import pfa_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [7:0]    gray_threshold_r;
  logic          alpha_present_r;
  logic          gray_check_enable_r;

  logic [31:0]   colour_r;
  logic          last_r;
  logic          transparent_seen_r;
  logic          still_gray_r;
  logic [CW-1:0] colour_count_r;
  logic          table_overflow_r;
  logic [CW-1:0] idx_r;
  logic          rd_pend_r;
  logic          found_r;
  logic [31:0]   rd_data_r;
  logic          out_valid_r;
  out_item_t     out_item_r;

  logic [31:0]   colour_table [TABLE_DEPTH];

  logic [7:0]    alpha_eff;
  logic [7:0]    diff_rg;
  logic [7:0]    diff_rb;
  logic          pix_not_gray;
  logic          hit;
  logic          table_full;
  logic [2:0]    class_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_threshold_r    <= '0;
      alpha_present_r     <= 1'b1;
      gray_check_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRAY_THRESHOLD:    gray_threshold_r    <= cfg_wdata;
        CFG_ALPHA_PRESENT:     alpha_present_r     <= cfg_wdata[0];
        CFG_GRAY_CHECK_ENABLE: gray_check_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign alpha_eff    = alpha_present_r ? in_item.alpha : 8'hFF;
  assign diff_rg      = (in_item.red > in_item.green) ? in_item.red - in_item.green
                                                      : in_item.green - in_item.red;
  assign diff_rb      = (in_item.red > in_item.blue) ? in_item.red - in_item.blue
                                                     : in_item.blue - in_item.red;
  assign pix_not_gray = gray_check_enable_r &&
                        ((diff_rg > gray_threshold_r) || (diff_rb > gray_threshold_r));

  assign hit        = rd_pend_r && (rd_data_r == colour_r);
  assign table_full = (colour_count_r == CW'(TABLE_DEPTH));

  // The search is skipped once the table has overflowed, since the class is
  // already settled.
  always_comb begin
    sts.scan_done = (idx_r == colour_count_r) || table_overflow_r;
    sts.rd_pend   = rd_pend_r;
    sts.last      = last_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    if (table_overflow_r) begin
      class_code = CLASS_NO_PAL;
    end else if (colour_count_r <= CW'(LIMIT_1BPP)) begin
      class_code = CLASS_1BPP;
    end else if (colour_count_r <= CW'(LIMIT_2BPP)) begin
      class_code = CLASS_2BPP;
    end else if (colour_count_r <= CW'(LIMIT_4BPP)) begin
      class_code = CLASS_4BPP;
    end else begin
      class_code = CLASS_8BPP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      colour_r <= {in_item.red, in_item.green, in_item.blue, alpha_eff};
      last_r   <= in_item.last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.load) begin
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
      found_r   <= found_r || hit;
      if (cmd.scan_rd) begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !found_r && !table_full) begin
      colour_table[colour_count_r[AW-1:0]] <= colour_r;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= colour_table[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transparent_seen_r <= 1'b0;
      still_gray_r       <= 1'b1;
      colour_count_r     <= '0;
      table_overflow_r   <= 1'b0;
    end else if (cmd.emit) begin
      transparent_seen_r <= 1'b0;
      still_gray_r       <= 1'b1;
      colour_count_r     <= '0;
      table_overflow_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (alpha_present_r && (in_item.alpha != 8'hFF)) begin
          transparent_seen_r <= 1'b1;
        end
        if (pix_not_gray) begin
          still_gray_r <= 1'b0;
        end
      end
      if (cmd.commit && !found_r) begin
        if (table_full) begin
          table_overflow_r <= 1'b1;
        end else begin
          colour_count_r <= colour_count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.is_transparent <= transparent_seen_r;
      out_item_r.is_grayscale   <= still_gray_r;
      out_item_r.colour_class   <= class_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule : pfa_dp
`default_nettype wire
